@@ hdl/sm83e_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sm83e_pkg
// Shared types and constants of the SM83 first-quarter execute block.
// ----------------------------------------------------------------------------
package sm83e_pkg;

    // Data memory address width and depth.
    localparam int ADDR_BITS = 16;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    // Item selector codes carried in the input tuser field.
    localparam logic [1:0] SEL_EXEC    = 2'd0;
    localparam logic [1:0] SEL_HOST_WR = 2'd1;
    localparam logic [1:0] SEL_HOST_RD = 2'd2;

    // Register pair values after reset.
    localparam logic [15:0] RST_PC = 16'h0100;
    localparam logic [15:0] RST_SP = 16'hFFFE;
    localparam logic [15:0] RST_AF = 16'h01B0;
    localparam logic [15:0] RST_BC = 16'h0013;
    localparam logic [15:0] RST_DE = 16'h00D8;
    localparam logic [15:0] RST_HL = 16'h014D;

    typedef struct packed {
        logic [15:0] pc;
        logic [15:0] sp;
        logic [15:0] af;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
    } t_regs;

    typedef struct packed {
        logic [1:0]  sel;
        logic [7:0]  ins;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [15:0] haddr;
        logic [7:0]  hdata;
    } t_item;

    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           wdata;
    } t_mem_req;

    typedef struct packed {
        t_regs      regs;
        logic [7:0] rd;
        logic       impl;
    } t_result;

endpackage
`default_nettype wire

@@ hdl/sm83e_exec.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sm83e_exec
// Decode and execute logic for one step of an item: the first step runs at
// acceptance, the second step finishes items that wait on the data memory.
// ----------------------------------------------------------------------------
module sm83e_exec (
    input  logic               i_phase,
    input  sm83e_pkg::t_item   i_item,
    input  sm83e_pkg::t_regs   i_regs,
    input  logic [7:0]         i_mem_rdata,
    output sm83e_pkg::t_regs   o_regs,
    output sm83e_pkg::t_mem_req o_mem,
    output logic               o_wait,
    output sm83e_pkg::t_result o_result
);

    // Opcode columns (low nibble of the instruction byte).
    localparam logic [3:0] COL_NOP      = 4'h0;
    localparam logic [3:0] COL_LD_RR    = 4'h1;
    localparam logic [3:0] COL_ST_IND   = 4'h2;
    localparam logic [3:0] COL_INC_RR   = 4'h3;
    localparam logic [3:0] COL_INC_R    = 4'h4;
    localparam logic [3:0] COL_DEC_R    = 4'h5;
    localparam logic [3:0] COL_LD_R     = 4'h6;
    localparam logic [3:0] COL_ROT_LO   = 4'h7;
    localparam logic [3:0] COL_ST_SP    = 4'h8;
    localparam logic [3:0] COL_ADD_HL   = 4'h9;
    localparam logic [3:0] COL_LD_IND   = 4'hA;
    localparam logic [3:0] COL_DEC_RR   = 4'hB;
    localparam logic [3:0] COL_INC_R_HI = 4'hC;
    localparam logic [3:0] COL_DEC_R_HI = 4'hD;
    localparam logic [3:0] COL_LD_R_HI  = 4'hE;
    localparam logic [3:0] COL_ROT_HI   = 4'hF;

    localparam logic [1:0] ROW_BC = 2'd0;
    localparam logic [1:0] ROW_DE = 2'd1;
    localparam logic [1:0] ROW_HL = 2'd2;
    localparam logic [1:0] ROW_SP = 2'd3;

    localparam logic [2:0] R8_B   = 3'd0;
    localparam logic [2:0] R8_C   = 3'd1;
    localparam logic [2:0] R8_D   = 3'd2;
    localparam logic [2:0] R8_E   = 3'd3;
    localparam logic [2:0] R8_H   = 3'd4;
    localparam logic [2:0] R8_L   = 3'd5;
    localparam logic [2:0] R8_MEM = 3'd6;

    localparam logic [1:0] ROT_RLCA = 2'd0;
    localparam logic [1:0] ROT_RRCA = 2'd1;
    localparam logic [1:0] ROT_RLA  = 2'd2;

    function automatic logic [7:0] get_r8(sm83e_pkg::t_regs rg, logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            R8_B:    v = rg.bc[15:8];
            R8_C:    v = rg.bc[7:0];
            R8_D:    v = rg.de[15:8];
            R8_E:    v = rg.de[7:0];
            R8_H:    v = rg.hl[15:8];
            R8_L:    v = rg.hl[7:0];
            default: v = rg.af[15:8];
        endcase
        return v;
    endfunction

    function automatic sm83e_pkg::t_regs set_r8(sm83e_pkg::t_regs rg, logic [2:0] idx,
                                                logic [7:0] v);
        sm83e_pkg::t_regs n;
        n = rg;
        case (idx)
            R8_B:    n.bc[15:8] = v;
            R8_C:    n.bc[7:0]  = v;
            R8_D:    n.de[15:8] = v;
            R8_E:    n.de[7:0]  = v;
            R8_H:    n.hl[15:8] = v;
            R8_L:    n.hl[7:0]  = v;
            default: n.af[15:8] = v;
        endcase
        return n;
    endfunction

    function automatic logic [15:0] get_rr(sm83e_pkg::t_regs rg, logic [1:0] idx);
        logic [15:0] v;
        case (idx)
            ROW_BC:  v = rg.bc;
            ROW_DE:  v = rg.de;
            ROW_HL:  v = rg.hl;
            default: v = rg.sp;
        endcase
        return v;
    endfunction

    function automatic sm83e_pkg::t_regs set_rr(sm83e_pkg::t_regs rg, logic [1:0] idx,
                                                logic [15:0] v);
        sm83e_pkg::t_regs n;
        n = rg;
        case (idx)
            ROW_BC:  n.bc = v;
            ROW_DE:  n.de = v;
            ROW_HL:  n.hl = v;
            default: n.sp = v;
        endcase
        return n;
    endfunction

    logic [3:0]  col;
    logic [1:0]  row;
    logic [2:0]  r8;
    logic [15:0] imm16;
    logic [15:0] st_sp_hi_addr;
    logic [15:0] rr_val;
    logic [15:0] ind_addr;
    logic [16:0] add_full;
    logic [12:0] add_half;
    logic        up;
    logic [7:0]  v8;
    logic [7:0]  res8;
    logic [3:0]  incdec_flags;
    logic [1:0]  rot_kind;
    logic [7:0]  acc;
    logic [7:0]  rot_acc;
    logic        rot_cout;
    logic        impl;
    logic [7:0]  rd;

    assign col           = i_item.ins[3:0];
    assign row           = i_item.ins[5:4];
    assign r8            = i_item.ins[5:3];
    assign imm16         = {i_item.hi, i_item.lo};
    assign st_sp_hi_addr = imm16 + 16'd1;
    assign rr_val        = get_rr(i_regs, row);
    assign ind_addr      = (row == ROW_BC) ? i_regs.bc :
                           (row == ROW_DE) ? i_regs.de : i_regs.hl;
    assign add_full      = {1'b0, i_regs.hl} + {1'b0, rr_val};
    assign add_half      = {1'b0, i_regs.hl[11:0]} + {1'b0, rr_val[11:0]};

    // 8-bit increment/decrement, shared by registers and the byte at (HL).
    assign up           = (col == COL_INC_R) || (col == COL_INC_R_HI);
    assign v8           = i_phase ? i_mem_rdata : get_r8(i_regs, r8);
    assign res8         = up ? (v8 + 8'd1) : (v8 - 8'd1);
    assign incdec_flags = {(res8 == 8'd0), !up,
                           up ? (v8[3:0] == 4'hF) : (v8[3:0] == 4'h0), i_regs.af[4]};

    // Accumulator rotates.
    assign rot_kind = {row[0], (col == COL_ROT_HI)};
    assign acc      = i_regs.af[15:8];
    always_comb begin
        case (rot_kind)
            ROT_RLCA: begin
                rot_cout = acc[7];
                rot_acc  = {acc[6:0], acc[7]};
            end
            ROT_RRCA: begin
                rot_cout = acc[0];
                rot_acc  = {acc[0], acc[7:1]};
            end
            ROT_RLA: begin
                rot_cout = acc[7];
                rot_acc  = {acc[6:0], i_regs.af[4]};
            end
            default: begin
                rot_cout = acc[0];
                rot_acc  = {i_regs.af[4], acc[7:1]};
            end
        endcase
    end

    always_comb begin
        o_regs = i_regs;
        o_mem  = '0;
        o_wait = 1'b0;
        impl   = 1'b0;
        rd     = 8'd0;
        if (!i_phase) begin
            case (i_item.sel)
                sm83e_pkg::SEL_HOST_WR: begin
                    o_mem.we    = 1'b1;
                    o_mem.addr  = i_item.haddr[sm83e_pkg::ADDR_BITS-1:0];
                    o_mem.wdata = i_item.hdata;
                end
                sm83e_pkg::SEL_HOST_RD: begin
                    o_mem.re   = 1'b1;
                    o_mem.addr = i_item.haddr[sm83e_pkg::ADDR_BITS-1:0];
                    o_wait     = 1'b1;
                end
                sm83e_pkg::SEL_EXEC: begin
                    o_regs.pc = i_regs.pc + 16'd1;
                    if (i_item.ins[7:6] == 2'b00) begin
                        case (col)
                            COL_LD_RR: begin
                                o_regs    = set_rr(i_regs, row, imm16);
                                o_regs.pc = i_regs.pc + 16'd3;
                                impl      = 1'b1;
                            end
                            COL_ST_IND, COL_LD_IND: begin
                                o_mem.addr = ind_addr[sm83e_pkg::ADDR_BITS-1:0];
                                if (col == COL_ST_IND) begin
                                    o_mem.we    = 1'b1;
                                    o_mem.wdata = i_regs.af[15:8];
                                    impl        = 1'b1;
                                end else begin
                                    o_mem.re = 1'b1;
                                    o_wait   = 1'b1;
                                end
                                // HL+ and HL- step after the access.
                                if (row == ROW_HL) begin
                                    o_regs.hl = i_regs.hl + 16'd1;
                                end else if (row == ROW_SP) begin
                                    o_regs.hl = i_regs.hl - 16'd1;
                                end
                            end
                            COL_INC_RR, COL_DEC_RR: begin
                                o_regs    = set_rr(i_regs, row, (col == COL_INC_RR) ?
                                                   (rr_val + 16'd1) : (rr_val - 16'd1));
                                o_regs.pc = i_regs.pc + 16'd1;
                                impl      = 1'b1;
                            end
                            COL_ST_SP: begin
                                if (row == ROW_BC) begin
                                    o_mem.we    = 1'b1;
                                    o_mem.addr  = imm16[sm83e_pkg::ADDR_BITS-1:0];
                                    o_mem.wdata = i_regs.sp[7:0];
                                    o_regs.pc   = i_regs.pc + 16'd3;
                                    o_wait      = 1'b1;
                                end
                            end
                            COL_ADD_HL: begin
                                o_regs.hl      = add_full[15:0];
                                o_regs.af[6:4] = {1'b0, add_half[12], add_full[16]};
                                impl           = 1'b1;
                            end
                            COL_INC_R, COL_DEC_R, COL_INC_R_HI, COL_DEC_R_HI: begin
                                if (r8 == R8_MEM) begin
                                    o_mem.re   = 1'b1;
                                    o_mem.addr = i_regs.hl[sm83e_pkg::ADDR_BITS-1:0];
                                    o_wait     = 1'b1;
                                end else begin
                                    o_regs         = set_r8(i_regs, r8, res8);
                                    o_regs.pc      = i_regs.pc + 16'd1;
                                    o_regs.af[7:0] = {incdec_flags, 4'h0};
                                    impl           = 1'b1;
                                end
                            end
                            COL_LD_R, COL_LD_R_HI: begin
                                if (r8 == R8_MEM) begin
                                    o_mem.we    = 1'b1;
                                    o_mem.addr  = i_regs.hl[sm83e_pkg::ADDR_BITS-1:0];
                                    o_mem.wdata = i_item.lo;
                                end else begin
                                    o_regs = set_r8(i_regs, r8, i_item.lo);
                                end
                                o_regs.pc = i_regs.pc + 16'd2;
                                impl      = 1'b1;
                            end
                            COL_ROT_LO, COL_ROT_HI: begin
                                // The upper two rows are DAA, CPL, SCF and CCF.
                                if (!row[1]) begin
                                    o_regs.af = {rot_acc, 3'b000, rot_cout, 4'h0};
                                    impl      = 1'b1;
                                end
                            end
                            COL_NOP: ;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end else begin
            // Second step: registers already hold the first-step updates.
            case (i_item.sel)
                sm83e_pkg::SEL_HOST_RD: begin
                    rd = i_mem_rdata;
                end
                sm83e_pkg::SEL_EXEC: begin
                    impl = 1'b1;
                    case (col)
                        COL_LD_IND: begin
                            o_regs.af[15:8] = i_mem_rdata;
                        end
                        COL_ST_SP: begin
                            o_mem.we    = 1'b1;
                            o_mem.addr  = st_sp_hi_addr[sm83e_pkg::ADDR_BITS-1:0];
                            o_mem.wdata = i_regs.sp[15:8];
                        end
                        default: begin
                            o_mem.we       = 1'b1;
                            o_mem.addr     = i_regs.hl[sm83e_pkg::ADDR_BITS-1:0];
                            o_mem.wdata    = res8;
                            o_regs.af[7:0] = {incdec_flags, 4'h0};
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_result = '{regs: o_regs, rd: rd, impl: impl};

endmodule
`default_nettype wire

@@ hdl/eight_bit_cpu_first_opcode_block.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eight_bit_cpu_first_opcode_block
// SM83 execute block for opcodes 0x00-0x3F with a byte data memory.
// ----------------------------------------------------------------------------
// Each input transaction carries either one instruction (opcode byte plus up
// to two operand bytes) or a host write or read of one data memory byte, and
// produces exactly one output transaction with all six register pairs after
// the item, the byte read by a host read, and an implemented flag. Most items
// complete when accepted, and their result is written into the output queue
// on acceptance. Host reads, LD A,(rr) and INC/DEC (HL) need a further step,
// set by the single port of the data memory and its registered read data.
// LD (a16),SP also needs a further step, because it writes two bytes through
// that one port. While such an item finishes its further step, the input is
// not ready. A two-entry output queue lets the block keep taking
// transactions while results wait downstream. Reading a memory byte that
// was never written returns an undefined value.
// ----------------------------------------------------------------------------
module eight_bit_cpu_first_opcode_block (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream.
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata from bit 0: instruction[7:0], imm_low[7:0], imm_high[7:0],
    // host_address[15:0], host_data[7:0].
    input  logic [47:0]  i_s_axis_tdata,
    // tuser: opcode[1:0] (0 execute, 1 host write, 2 host read).
    input  logic [1:0]   i_s_axis_tuser,
    // Output stream.
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata from bit 0: prog_counter[15:0], stack_pointer[15:0],
    // acc_flags[15:0], pair_bc[15:0], pair_de[15:0], pair_hl[15:0],
    // read_data[7:0].
    output logic [103:0] o_m_axis_tdata,
    // tuser: implemented[0].
    output logic [0:0]   o_m_axis_tuser
);

    sm83e_pkg::t_item     in_item;
    sm83e_pkg::t_item     cur_item;
    sm83e_pkg::t_regs     exec_regs;
    sm83e_pkg::t_mem_req  exec_mem;
    sm83e_pkg::t_result   exec_result;
    logic                 exec_wait;

    // Architectural register pairs, kept in flip-flops next to the memory.
    sm83e_pkg::t_regs     r_regs;
    // The item that waits for its memory read data; its phase flag.
    sm83e_pkg::t_item     r_item;
    logic                 r_busy;

    // Byte data memory, one synchronous port with registered read data.
    logic [7:0]           r_mem [sm83e_pkg::MEM_DEPTH];
    logic [7:0]           r_mem_rdata;

    // Output queue of two results.
    sm83e_pkg::t_result   r_q [2];
    logic                 r_wptr;
    logic                 r_rptr;
    logic [1:0]           r_cnt;
    logic [1:0]           n_cnt;

    logic                 accept;
    logic                 fire;
    logic                 push;
    logic                 pop;
    sm83e_pkg::t_result   q_head;

    assign in_item = '{sel:   i_s_axis_tuser,
                       ins:   i_s_axis_tdata[7:0],
                       lo:    i_s_axis_tdata[15:8],
                       hi:    i_s_axis_tdata[23:16],
                       haddr: i_s_axis_tdata[39:24],
                       hdata: i_s_axis_tdata[47:40]};

    // A new transaction is taken when no item waits on memory and the queue
    // will have a free slot for its result.
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = !r_busy && ((r_cnt != 2'd2) || pop);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // The second step of a waiting item runs in the cycle after acceptance;
    // no new transaction is taken in that cycle, so register and memory
    // accesses of consecutive items never overlap.
    assign cur_item = r_busy ? r_item : in_item;
    assign fire     = accept || r_busy;
    assign push     = (accept && !exec_wait) || r_busy;

    sm83e_exec u_exec (
        .i_phase     (r_busy),
        .i_item      (cur_item),
        .i_regs      (r_regs),
        .i_mem_rdata (r_mem_rdata),
        .o_regs      (exec_regs),
        .o_mem       (exec_mem),
        .o_wait      (exec_wait),
        .o_result    (exec_result)
    );

    always_ff @(posedge i_clk) begin
        if (fire && exec_mem.we) begin
            r_mem[exec_mem.addr] <= exec_mem.wdata;
        end
        if (fire && exec_mem.re) begin
            r_mem_rdata <= r_mem[exec_mem.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= in_item;
        end
        if (push) begin
            r_q[r_wptr] <= exec_result;
        end
    end

    assign n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '{pc: sm83e_pkg::RST_PC, sp: sm83e_pkg::RST_SP,
                        af: sm83e_pkg::RST_AF, bc: sm83e_pkg::RST_BC,
                        de: sm83e_pkg::RST_DE, hl: sm83e_pkg::RST_HL};
            r_busy <= 1'b0;
            r_cnt  <= 2'd0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            if (fire) begin
                r_regs <= exec_regs;
            end
            if (r_busy) begin
                r_busy <= 1'b0;
            end else if (accept && exec_wait) begin
                r_busy <= 1'b1;
            end
            r_cnt <= n_cnt;
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    assign q_head          = r_q[r_rptr];
    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = {q_head.rd, q_head.regs.hl, q_head.regs.de, q_head.regs.bc,
                              q_head.regs.af, q_head.regs.sp, q_head.regs.pc};
    assign o_m_axis_tuser  = q_head.impl;

endmodule
`default_nettype wire

@@ hdl/sm83e_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sm83e_checker
// Port-level checks of the SM83 execute block, bound to its top level.
// ----------------------------------------------------------------------------
module sm83e_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [103:0] o_m_axis_tdata,
    input logic [0:0]   o_m_axis_tuser
);

    // No result is offered right after reset.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result stays offered and unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output data changed while stalled");

    // The low nibble of the flag register never becomes set.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[35:32] == 4'h0))
        else $error("flag bits 3..0 set");

    // Implemented instructions never report host read data.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> (o_m_axis_tdata[103:96] == 8'h00))
        else $error("read data present on an executed instruction");

endmodule

bind eight_bit_cpu_first_opcode_block sm83e_checker u_sm83e_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SM83 first-quarter execute block.
// ----------------------------------------------------------------------------
// The bench drives instruction and host memory transactions into the input
// stream. An architectural model of the register file and the data memory
// works out the state that each transaction must leave, and every output
// transaction is compared field by field with the oldest prediction.
//
// The run starts with a short table of hand-picked transactions. Some carry
// their answer typed in, and the model answers the others. Three random
// phases follow with different idle patterns on either stream. Memory that
// was never written is never read: a transaction that would read such a byte
// is turned into a host write of that byte instead.
// ----------------------------------------------------------------------------
module tb_top;
    import sm83e_pkg::*;

    // Selector code with no function; the block must leave everything as is.
    localparam logic [1:0] SEL_NONE = 2'd3;

    // Instruction bytes used by the directed table.
    localparam logic [7:0] OP_NOP        = 8'h00;
    localparam logic [7:0] OP_LD_BC_D16  = 8'h01;
    localparam logic [7:0] OP_INC_BC     = 8'h03;
    localparam logic [7:0] OP_RLCA       = 8'h07;
    localparam logic [7:0] OP_LD_A16_SP  = 8'h08;
    localparam logic [7:0] OP_LD_DE_D16  = 8'h11;
    localparam logic [7:0] OP_JR         = 8'h18;
    localparam logic [7:0] OP_LD_A_DE    = 8'h1A;
    localparam logic [7:0] OP_RRA        = 8'h1F;
    localparam logic [7:0] OP_LD_HL_D16  = 8'h21;
    localparam logic [7:0] OP_LD_HLI_A   = 8'h22;
    localparam logic [7:0] OP_DAA        = 8'h27;
    localparam logic [7:0] OP_LD_SP_D16  = 8'h31;
    localparam logic [7:0] OP_INC_HLM    = 8'h34;
    localparam logic [7:0] OP_DEC_HLM    = 8'h35;
    localparam logic [7:0] OP_LD_HLM_D8  = 8'h36;
    localparam logic [7:0] OP_ADD_HL_SP  = 8'h39;
    localparam logic [7:0] OP_LD_A_HLD   = 8'h3A;
    localparam logic [7:0] OP_DEC_SP     = 8'h3B;
    localparam logic [7:0] OP_INC_A      = 8'h3C;
    localparam logic [7:0] OP_DEC_A      = 8'h3D;
    localparam logic [7:0] OP_RST_38     = 8'hFF;
    localparam logic [7:0] OP_FIRST_UNIT = 8'h40;

    // Low nibble of the opcode selects the instruction group.
    localparam logic [3:0] COL_NOP      = 4'h0;
    localparam logic [3:0] COL_LD_RR    = 4'h1;
    localparam logic [3:0] COL_ST_IND   = 4'h2;
    localparam logic [3:0] COL_INC_RR   = 4'h3;
    localparam logic [3:0] COL_INC_R_LO = 4'h4;
    localparam logic [3:0] COL_DEC_R_LO = 4'h5;
    localparam logic [3:0] COL_LD_R_LO  = 4'h6;
    localparam logic [3:0] COL_ROT_LO   = 4'h7;
    localparam logic [3:0] COL_ST_SP    = 4'h8;
    localparam logic [3:0] COL_ADD_HL   = 4'h9;
    localparam logic [3:0] COL_LD_IND   = 4'hA;
    localparam logic [3:0] COL_DEC_RR   = 4'hB;
    localparam logic [3:0] COL_INC_R_HI = 4'hC;
    localparam logic [3:0] COL_DEC_R_HI = 4'hD;
    localparam logic [3:0] COL_LD_R_HI  = 4'hE;
    localparam logic [3:0] COL_ROT_HI   = 4'hF;

    // Register pair codes (opcode bits 5:4) and 8-bit register codes.
    localparam logic [1:0] RR_BC = 2'd0;
    localparam logic [1:0] RR_DE = 2'd1;
    localparam logic [1:0] RR_HL = 2'd2;
    localparam logic [1:0] RR_SP = 2'd3;
    localparam logic [1:0] IND_HLI = 2'd2;
    localparam logic [2:0] R8_B   = 3'd0;
    localparam logic [2:0] R8_C   = 3'd1;
    localparam logic [2:0] R8_D   = 3'd2;
    localparam logic [2:0] R8_E   = 3'd3;
    localparam logic [2:0] R8_H   = 3'd4;
    localparam logic [2:0] R8_L   = 3'd5;
    localparam logic [2:0] R8_HLM = 3'd6;

    // Accumulator rotate kinds.
    localparam logic [1:0] ROT_RLCA = 2'd0;
    localparam logic [1:0] ROT_RRCA = 2'd1;
    localparam logic [1:0] ROT_RLA  = 2'd2;

    // Flag bit positions in the low byte of AF.
    localparam int FLAG_Z = 7;
    localparam int FLAG_N = 6;
    localparam int FLAG_H = 5;
    localparam int FLAG_C = 4;

    // Random memory traffic is steered into a small window so that loads
    // through register pairs find written bytes most of the time.
    localparam logic [7:0] WINDOW_HI   = 8'hC0;
    localparam int         WINDOW_SPAN = 32;

    localparam int RANDOM_PER_PHASE = 550;
    localparam int HOLD_CYCLES      = 200;
    localparam int DRAIN_CYCLES     = 10;
    localparam int WATCHDOG_LIMIT   = 2000;

    typedef struct packed {
        t_item   it;
        logic    typed;
        t_result want;
    } t_dir_row;

    localparam t_result NO_RESULT = '0;

    // Directed table. Rows with typed set carry an answer that can be read
    // straight off the reset state; the model answers the others.
    localparam t_dir_row DIRECTED [0:25] = '{
        // NOP right after reset: only PC moves.
        '{'{SEL_EXEC, OP_NOP, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b1,
          '{'{16'h0101, 16'hFFFE, 16'h01B0, 16'h0013, 16'h00D8, 16'h014D}, 8'h00, 1'b0}},
        // Selector three with every data bit set changes nothing at all.
        '{'{SEL_NONE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1,
          '{'{16'h0101, 16'hFFFE, 16'h01B0, 16'h0013, 16'h00D8, 16'h014D}, 8'h00, 1'b0}},
        '{'{SEL_EXEC, OP_LD_BC_D16, 8'hFF, 8'hFF, 16'h0000, 8'h00}, 1'b1,
          '{'{16'h0104, 16'hFFFE, 16'h01B0, 16'hFFFF, 16'h00D8, 16'h014D}, 8'h00, 1'b1}},
        // 16-bit increment wraps to zero.
        '{'{SEL_EXEC, OP_INC_BC, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b1,
          '{'{16'h0105, 16'hFFFE, 16'h01B0, 16'h0000, 16'h00D8, 16'h014D}, 8'h00, 1'b1}},
        '{'{SEL_EXEC, OP_LD_SP_D16, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b1,
          '{'{16'h0108, 16'h0000, 16'h01B0, 16'h0000, 16'h00D8, 16'h014D}, 8'h00, 1'b1}},
        // 16-bit decrement wraps to all ones.
        '{'{SEL_EXEC, OP_DEC_SP, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b1,
          '{'{16'h0109, 16'hFFFF, 16'h01B0, 16'h0000, 16'h00D8, 16'h014D}, 8'h00, 1'b1}},
        // SP store at the top address: the high byte wraps to address zero.
        '{'{SEL_EXEC, OP_LD_A16_SP, 8'hFF, 8'hFF, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_HOST_RD, OP_NOP, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_EXEC, OP_LD_HL_D16, 8'hFF, 8'hFF, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        // HL post-increment and post-decrement across the address wrap.
        '{'{SEL_EXEC, OP_LD_HLI_A, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_EXEC, OP_LD_A_HLD, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        // Both half carry and carry out of ADD HL.
        '{'{SEL_EXEC, OP_ADD_HL_SP, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_EXEC, OP_LD_HLM_D8, 8'h0F, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_EXEC, OP_INC_HLM, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_EXEC, OP_DEC_HLM, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_HOST_WR, OP_NOP, 8'h00, 8'h00, 16'h8000, 8'hFF}, 1'b0, NO_RESULT},
        '{'{SEL_EXEC, OP_LD_DE_D16, 8'h00, 8'h80, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_EXEC, OP_LD_A_DE, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        // A goes 0xFF -> 0x00 -> 0xFF: zero, half carry and borrow flags.
        '{'{SEL_EXEC, OP_INC_A, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_EXEC, OP_DEC_A, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_EXEC, OP_RLCA, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_EXEC, OP_RRA, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        // Not implemented: PC moves by one, operand bytes are ignored.
        '{'{SEL_EXEC, OP_DAA, 8'hFF, 8'hFF, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_EXEC, OP_JR, 8'h55, 8'hAA, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_EXEC, OP_RST_38, 8'hAA, 8'h55, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
        '{'{SEL_HOST_RD, OP_NOP, 8'h00, 8'h00, 16'h8000, 8'h00}, 1'b0, NO_RESULT}
    };

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // tdata from bit 0: instruction, imm_low, imm_high, host_address, host_data.
    logic [47:0]  i_s_axis_tdata = '0;
    // tuser: opcode (item selector).
    logic [1:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // tdata from bit 0: PC, SP, AF, BC, DE, HL, read_data.
    logic [103:0] o_m_axis_tdata;
    // tuser: implemented.
    logic [0:0]   o_m_axis_tuser;

    // Architectural state as the block should hold it after every accepted
    // transaction, and the results still owed by the block.
    t_regs      arch_regs;
    logic [7:0] data_mem [MEM_DEPTH];
    bit         mem_written [MEM_DEPTH];
    t_result    owed_states [$];

    int send_idle_pct = 38;
    int recv_idle_pct = 62;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;

    eight_bit_cpu_first_opcode_block DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Architectural model.
    // ------------------------------------------------------------------
    function automatic logic [7:0] mem_load(input logic [15:0] addr);
        return data_mem[addr[ADDR_BITS-1:0]];
    endfunction

    function automatic void mem_store(input logic [15:0] addr, input logic [7:0] v);
        data_mem[addr[ADDR_BITS-1:0]] = v;
        mem_written[addr[ADDR_BITS-1:0]] = 1'b1;
    endfunction

    function automatic logic [15:0] pair_read(input logic [1:0] rr);
        case (rr)
            RR_BC: return arch_regs.bc;
            RR_DE: return arch_regs.de;
            RR_HL: return arch_regs.hl;
            default: return arch_regs.sp;
        endcase
    endfunction

    function automatic void pair_write(input logic [1:0] rr, input logic [15:0] v);
        case (rr)
            RR_BC: arch_regs.bc = v;
            RR_DE: arch_regs.de = v;
            RR_HL: arch_regs.hl = v;
            default: arch_regs.sp = v;
        endcase
    endfunction

    // Code 6 stands for (HL) and never reaches these two.
    function automatic logic [7:0] reg8_read(input logic [2:0] r);
        case (r)
            R8_B: return arch_regs.bc[15:8];
            R8_C: return arch_regs.bc[7:0];
            R8_D: return arch_regs.de[15:8];
            R8_E: return arch_regs.de[7:0];
            R8_H: return arch_regs.hl[15:8];
            R8_L: return arch_regs.hl[7:0];
            default: return arch_regs.af[15:8];
        endcase
    endfunction

    function automatic void reg8_write(input logic [2:0] r, input logic [7:0] v);
        case (r)
            R8_B: arch_regs.bc[15:8] = v;
            R8_C: arch_regs.bc[7:0] = v;
            R8_D: arch_regs.de[15:8] = v;
            R8_E: arch_regs.de[7:0] = v;
            R8_H: arch_regs.hl[15:8] = v;
            R8_L: arch_regs.hl[7:0] = v;
            default: arch_regs.af[15:8] = v;
        endcase
    endfunction

    // Address used by the indirect load and store group; HL steps after use.
    function automatic logic [15:0] indirect_addr(input logic [1:0] row);
        logic [15:0] addr;
        addr = (row == RR_BC) ? arch_regs.bc : (row == RR_DE) ? arch_regs.de : arch_regs.hl;
        if (row == IND_HLI)
            arch_regs.hl = addr + 16'd1;
        else if (row == RR_SP)
            arch_regs.hl = addr - 16'd1;
        return addr;
    endfunction

    // Applies one accepted transaction to the architectural state and
    // returns what the block must report for it.
    task automatic execute_item(input t_item it, output t_result res);
        logic [3:0]  col;
        logic [1:0]  row;
        logic [2:0]  r;
        logic [15:0] pc0;
        logic [15:0] imm16;
        logic [15:0] addr;
        logic [15:0] other;
        logic [16:0] sum17;
        logic [12:0] sum13;
        logic [7:0]  v;
        logic [7:0]  a;
        logic [1:0]  kind;
        logic        cout;

        col = it.ins[3:0];
        row = it.ins[5:4];
        r = it.ins[5:3];
        imm16 = {it.hi, it.lo};
        res = '0;
        if (it.sel == SEL_HOST_WR) begin
            mem_store(it.haddr, it.hdata);
        end else if (it.sel == SEL_HOST_RD) begin
            res.rd = mem_load(it.haddr);
        end else if (it.sel == SEL_EXEC) begin
            pc0 = arch_regs.pc;
            arch_regs.pc = pc0 + 16'd1;
            if (it.ins < OP_FIRST_UNIT) begin
                res.impl = 1'b1;
                case (col)
                    COL_NOP: begin
                        res.impl = 1'b0;
                    end
                    COL_LD_RR: begin
                        pair_write(row, imm16);
                        arch_regs.pc = pc0 + 16'd3;
                    end
                    COL_ST_IND: begin
                        addr = indirect_addr(row);
                        mem_store(addr, arch_regs.af[15:8]);
                    end
                    COL_LD_IND: begin
                        addr = indirect_addr(row);
                        arch_regs.af[15:8] = mem_load(addr);
                    end
                    COL_INC_RR: pair_write(row, pair_read(row) + 16'd1);
                    COL_DEC_RR: pair_write(row, pair_read(row) - 16'd1);
                    COL_ST_SP: begin
                        if (row != RR_BC) begin
                            res.impl = 1'b0;
                        end else begin
                            mem_store(imm16, arch_regs.sp[7:0]);
                            mem_store(imm16 + 16'd1, arch_regs.sp[15:8]);
                            arch_regs.pc = pc0 + 16'd3;
                        end
                    end
                    COL_ADD_HL: begin
                        other = pair_read(row);
                        sum13 = {1'b0, arch_regs.hl[11:0]} + {1'b0, other[11:0]};
                        sum17 = {1'b0, arch_regs.hl} + {1'b0, other};
                        arch_regs.af[FLAG_N] = 1'b0;
                        arch_regs.af[FLAG_H] = sum13[12];
                        arch_regs.af[FLAG_C] = sum17[16];
                        arch_regs.hl = sum17[15:0];
                    end
                    COL_INC_R_LO, COL_INC_R_HI, COL_DEC_R_LO, COL_DEC_R_HI: begin
                        v = (r == R8_HLM) ? mem_load(arch_regs.hl) : reg8_read(r);
                        if (col == COL_INC_R_LO || col == COL_INC_R_HI) begin
                            arch_regs.af[FLAG_N] = 1'b0;
                            arch_regs.af[FLAG_H] = (v[3:0] == 4'hF);
                            v = v + 8'd1;
                        end else begin
                            arch_regs.af[FLAG_N] = 1'b1;
                            arch_regs.af[FLAG_H] = (v[3:0] == 4'h0);
                            v = v - 8'd1;
                        end
                        arch_regs.af[FLAG_Z] = (v == 8'h00);
                        if (r == R8_HLM)
                            mem_store(arch_regs.hl, v);
                        else
                            reg8_write(r, v);
                    end
                    COL_LD_R_LO, COL_LD_R_HI: begin
                        if (r == R8_HLM)
                            mem_store(arch_regs.hl, it.lo);
                        else
                            reg8_write(r, it.lo);
                        arch_regs.pc = pc0 + 16'd2;
                    end
                    default: begin
                        // Rotates live in the first two rows only.
                        if (row[1]) begin
                            res.impl = 1'b0;
                        end else begin
                            kind = {row[0], col == COL_ROT_HI};
                            a = arch_regs.af[15:8];
                            cout = kind[0] ? a[0] : a[7];
                            case (kind)
                                ROT_RLCA: a = {a[6:0], a[7]};
                                ROT_RRCA: a = {a[0], a[7:1]};
                                ROT_RLA:  a = {a[6:0], arch_regs.af[FLAG_C]};
                                default:  a = {arch_regs.af[FLAG_C], a[7:1]};
                            endcase
                            arch_regs.af[15:8] = a;
                            arch_regs.af[FLAG_Z] = 1'b0;
                            arch_regs.af[FLAG_N] = 1'b0;
                            arch_regs.af[FLAG_H] = 1'b0;
                            arch_regs.af[FLAG_C] = cout;
                        end
                    end
                endcase
            end
        end
        res.regs = arch_regs;
    endtask

    // Tells whether a transaction would read a byte that was never written,
    // and which address that is.
    function automatic logic reads_unwritten(input t_item it, output logic [15:0] addr);
        logic [3:0] col;
        logic       reads;

        col = it.ins[3:0];
        reads = 1'b0;
        addr = arch_regs.hl;
        if (it.sel == SEL_HOST_RD) begin
            reads = 1'b1;
            addr = it.haddr;
        end else if (it.sel == SEL_EXEC && it.ins < OP_FIRST_UNIT) begin
            if (col == COL_LD_IND) begin
                reads = 1'b1;
                if (it.ins[5:4] == RR_BC)
                    addr = arch_regs.bc;
                else if (it.ins[5:4] == RR_DE)
                    addr = arch_regs.de;
            end else if (it.ins == OP_INC_HLM || it.ins == OP_DEC_HLM) begin
                reads = 1'b1;
            end
        end
        return reads && !mem_written[addr[ADDR_BITS-1:0]];
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    pick;

        it.sel = SEL_EXEC;
        it.ins = 8'($urandom);
        it.lo = 8'($urandom);
        it.hi = 8'($urandom);
        it.haddr = 16'($urandom);
        it.hdata = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 50) begin
            // Implemented quarter; half of the immediates point into the window.
            it.ins = 8'($urandom_range(63));
            if ($urandom_range(1) == 1) begin
                it.hi = WINDOW_HI;
                it.lo = 8'($urandom_range(WINDOW_SPAN - 1));
            end
        end else if (pick < 60) begin
            it.ins = 8'($urandom_range(255, 64));
        end else if (pick < 78) begin
            it.sel = SEL_HOST_WR;
            if ($urandom_range(2) != 0)
                it.haddr = {WINDOW_HI, 8'($urandom_range(WINDOW_SPAN - 1))};
        end else if (pick < 95) begin
            it.sel = SEL_HOST_RD;
            if ($urandom_range(9) != 0)
                it.haddr = {WINDOW_HI, 8'($urandom_range(WINDOW_SPAN - 1))};
        end else begin
            it.sel = SEL_NONE;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Input stream driver.
    // ------------------------------------------------------------------
    // Offers one transaction, with a random gap first, and records the
    // prediction when it is accepted. tvalid stays high between back-to-back
    // transactions so that it is never lowered and raised in one step.
    task automatic send_item(input t_item it, input logic typed, input t_result want);
        t_result predicted;

        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {it.hdata, it.haddr, it.hi, it.lo, it.ins};
        i_s_axis_tuser <= it.sel;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        execute_item(it, predicted);
        owed_states.push_back(typed ? want : predicted);
    endtask

    // Stops offering until the block has handed back every owed result.
    task automatic wait_for_drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (owed_states.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Output stream monitor and checker.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        t_result want;
        t_result got;

        got.regs.pc = o_m_axis_tdata[15:0];
        got.regs.sp = o_m_axis_tdata[31:16];
        got.regs.af = o_m_axis_tdata[47:32];
        got.regs.bc = o_m_axis_tdata[63:48];
        got.regs.de = o_m_axis_tdata[79:64];
        got.regs.hl = o_m_axis_tdata[95:80];
        got.rd = o_m_axis_tdata[103:96];
        got.impl = o_m_axis_tuser[0];
        if (owed_states.size() == 0) begin
            mismatches++;
            $display("%0t: result transaction with nothing owed, expected none, actual %h",
                     $time, o_m_axis_tdata);
        end else begin
            want = owed_states.pop_front();
            check_field("PC", want.regs.pc, got.regs.pc);
            check_field("SP", want.regs.sp, got.regs.sp);
            check_field("AF", want.regs.af, got.regs.af);
            check_field("BC", want.regs.bc, got.regs.bc);
            check_field("DE", want.regs.de, got.regs.de);
            check_field("HL", want.regs.hl, got.regs.hl);
            check_field("read_data", {8'h00, want.rd}, {8'h00, got.rd});
            check_field("implemented", {15'h0000, want.impl}, {15'h0000, got.impl});
        end
    endtask

    // The receiver checks each accepted result and picks its ready for the
    // next cycle. A hold request from the stimulus makes it refuse results
    // for a long stretch so that the block backs up into its input.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_result();
            if (hold_seen != hold_requests) begin
                hold_seen <= hold_requests;
                hold_left <= HOLD_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: too long without a transaction on either stream ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("** eight_bit_cpu_first_opcode_block: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin
        t_item       it;
        logic [15:0] addr;
        int          phase;

        arch_regs = '{RST_PC, RST_SP, RST_AF, RST_BC, RST_DE, RST_HL};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < $size(DIRECTED); n++)
            send_item(DIRECTED[n].it, DIRECTED[n].typed, DIRECTED[n].want);

        // Phase 0: sender idles 38%, receiver 62%. Phase 1: the reverse,
        // opened by a full drain. Phase 2: no idling, opened by a long
        // receiver hold while the sender keeps offering.
        for (phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                wait_for_drain();
                send_idle_pct = 62;
                recv_idle_pct <= 38;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                hold_requests <= hold_requests + 1;
            end
            repeat (RANDOM_PER_PHASE) begin
                it = random_item();
                if (reads_unwritten(it, addr)) begin
                    it.sel = SEL_HOST_WR;
                    it.haddr = addr;
                end
                if ($urandom_range(199) == 0)
                    wait_for_drain();
                send_item(it, 1'b0, NO_RESULT);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (owed_states.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** eight_bit_cpu_first_opcode_block: PASSED **");
        end else begin
            $display("** eight_bit_cpu_first_opcode_block: FAILED **");
        end
        $finish;
    end

endmodule
